// ----- sv/utf8v_pkg.sv -----
// Shared types and constants for the UTF-8 stream validator.
`default_nettype none

package utf8v_pkg;

   // Byte boundaries of the RFC 3629 grammar.
   localparam logic [7:0] ASCII_MAX      = 8'h7f;
   localparam logic [7:0] LEAD2_MIN      = 8'hc2;
   localparam logic [7:0] LEAD2_MAX      = 8'hdf;
   localparam logic [7:0] LEAD3_MIN      = 8'he0;
   localparam logic [7:0] LEAD3_SURR     = 8'hed;
   localparam logic [7:0] LEAD4_MIN      = 8'hf0;
   localparam logic [7:0] LEAD4_MAX      = 8'hf4;
   localparam logic [7:0] CONT_A0        = 8'ha0;
   localparam logic [7:0] CONT_9F        = 8'h9f;
   localparam logic [7:0] CONT_90        = 8'h90;
   localparam logic [7:0] CONT_8F        = 8'h8f;
   localparam logic [1:0] CONT_TAG       = 2'b10;

   localparam int unsigned POS_BITS = 32;

   // Register indexes of the configuration port.
   localparam logic REG_REPORT_CHAR_START = 1'b0;

   // Narrowing of the first continuation byte after certain lead bytes.
   typedef enum logic [2:0] {
      RULE_ANY   = 3'd0,
      RULE_A0_BF = 3'd1,
      RULE_80_9F = 3'd2,
      RULE_90_BF = 3'd3,
      RULE_80_8F = 3'd4
   } rule_type;

   typedef struct packed {
      logic [POS_BITS-1:0] position;
      logic                position_found;
      logic                stopped;
      logic                sequence_valid;
      logic                final_result;
   } result_type;

endpackage

`default_nettype wire

// ----- sv/utf8v_csr.sv -----
// Configuration register block with an APB-style access port.
`default_nettype none

module utf8v_csr
   import utf8v_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic             report_char_start
);

   logic report_char_start_ff;
   logic report_char_start_in;
   logic wr_en;

   // The two low address bits take no part in decoding.
   assign wr_en = psel & penable & pwrite & (paddr[2] == REG_REPORT_CHAR_START);

   always_comb begin
      report_char_start_in = report_char_start_ff;
      if (wr_en) begin
         report_char_start_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         report_char_start_ff <= 1'b0;
      end else begin
         report_char_start_ff <= report_char_start_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_REPORT_CHAR_START) begin
         prdata = {31'd0, report_char_start_ff};
      end
   end

   assign pready            = 1'b1;
   assign report_char_start = report_char_start_ff;

endmodule

`default_nettype wire

// ----- sv/utf8v_core.sv -----
// Per-byte UTF-8 grammar check with the running offsets of the sequence.
`default_nettype none

module utf8v_core
   import utf8v_pkg::*;
#(
   parameter int unsigned OFFSET_BITS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] data_byte,
   input  wire logic       last,
   input  wire logic       report_char_start,
   output result_type      result
);

   logic                   halted_ff, halted_in;
   logic [1:0]             need_ff, need_in;
   rule_type               rule_ff, rule_in;
   logic [OFFSET_BITS-1:0] seen_ff, seen_in;
   logic [OFFSET_BITS-1:0] pending_ff, pending_in;
   logic [OFFSET_BITS-1:0] prefix_end_ff, prefix_end_in;
   logic [OFFSET_BITS-1:0] char_start_ff, char_start_in;
   logic                   char_seen_ff, char_seen_in;

   logic [OFFSET_BITS-1:0] seen_inc;
   logic                   cont_ok;
   logic [OFFSET_BITS-1:0] pos_sel;
   logic                   found;

   // Offsets stick at the top of their range.
   assign seen_inc = (seen_ff == '1) ? seen_ff : seen_ff + OFFSET_BITS'(1);

   always_comb begin
      unique case (rule_ff)
         RULE_A0_BF: cont_ok = (data_byte >= CONT_A0) && (data_byte[7:6] == CONT_TAG);
         RULE_80_9F: cont_ok = (data_byte[7:6] == CONT_TAG) && (data_byte <= CONT_9F);
         RULE_90_BF: cont_ok = (data_byte >= CONT_90) && (data_byte[7:6] == CONT_TAG);
         RULE_80_8F: cont_ok = (data_byte[7:6] == CONT_TAG) && (data_byte <= CONT_8F);
         default:    cont_ok = (data_byte[7:6] == CONT_TAG);
      endcase
   end

   always_comb begin
      halted_in     = halted_ff;
      need_in       = need_ff;
      rule_in       = rule_ff;
      seen_in       = seen_ff;
      pending_in    = pending_ff;
      prefix_end_in = prefix_end_ff;
      char_start_in = char_start_ff;
      char_seen_in  = char_seen_ff;
      if (!halted_ff) begin
         if (need_ff != 2'd0) begin
            if (!cont_ok) begin
               // A bad continuation leaves the prefix at the unfinished character's start.
               halted_in = 1'b1;
            end else begin
               rule_in = RULE_ANY;
               need_in = need_ff - 2'd1;
               seen_in = seen_inc;
               if (need_ff == 2'd1) begin
                  char_start_in = pending_ff;
                  prefix_end_in = seen_inc;
                  char_seen_in  = 1'b1;
               end
            end
         end else begin
            pending_in = seen_ff;
            priority if (data_byte <= ASCII_MAX) begin
               char_start_in = seen_ff;
               prefix_end_in = seen_inc;
               char_seen_in  = 1'b1;
               seen_in       = seen_inc;
            end else if (data_byte < LEAD2_MIN) begin
               halted_in = 1'b1;
            end else if (data_byte <= LEAD2_MAX) begin
               need_in = 2'd1;
               rule_in = RULE_ANY;
               seen_in = seen_inc;
            end else if (data_byte < LEAD4_MIN) begin
               need_in = 2'd2;
               rule_in = (data_byte == LEAD3_MIN)  ? RULE_A0_BF :
                         (data_byte == LEAD3_SURR) ? RULE_80_9F : RULE_ANY;
               seen_in = seen_inc;
            end else if (data_byte <= LEAD4_MAX) begin
               need_in = 2'd3;
               rule_in = (data_byte == LEAD4_MIN) ? RULE_90_BF :
                         (data_byte == LEAD4_MAX) ? RULE_80_8F : RULE_ANY;
               seen_in = seen_inc;
            end else begin
               halted_in = 1'b1;
            end
         end
      end
   end

   // The result reflects the state after this byte.
   always_comb begin
      if (report_char_start) begin
         pos_sel = char_seen_in ? char_start_in : '0;
         found   = char_seen_in;
      end else begin
         pos_sel = prefix_end_in;
         found   = 1'b1;
      end
   end

   generate
      if (OFFSET_BITS >= POS_BITS) begin : g_pos_trunc
         assign result.position = pos_sel[POS_BITS-1:0];
      end else begin : g_pos_ext
         assign result.position = {{(POS_BITS-OFFSET_BITS){1'b0}}, pos_sel};
      end
   endgenerate

   assign result.position_found = found;
   assign result.stopped        = halted_in;
   assign result.sequence_valid = last & ~halted_in & (need_in == 2'd0);
   assign result.final_result   = last;

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         halted_ff     <= 1'b0;
         need_ff       <= 2'd0;
         rule_ff       <= RULE_ANY;
         seen_ff       <= '0;
         pending_ff    <= '0;
         prefix_end_ff <= '0;
         char_start_ff <= '0;
         char_seen_ff  <= 1'b0;
      end else if (step) begin
         halted_ff     <= halted_in;
         need_ff       <= need_in;
         rule_ff       <= rule_in;
         seen_ff       <= seen_in;
         pending_ff    <= pending_in;
         prefix_end_ff <= prefix_end_in;
         char_start_ff <= char_start_in;
         char_seen_ff  <= char_seen_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/utf8_stream_validator.sv -----
// Top level of the UTF-8 stream validator: input register, check logic, result register.
//
//   Channel | Direction | Handshake        | Payload
//   req     | in        | req_valid/stall  | data_byte, end_of_sequence
//   rsp     | out       | rsp_valid/stall  | position, position_found, stopped,
//           |           |                  | sequence_valid, final_result
//   csr     | in/out    | psel/penable     | report_char_start at byte address 0
//
// One byte a cycle sustained while rsp is not stalled; an accepted request is held in
// the input register; one pass of utf8v_core grammar logic fills the result register.
// Synchronous reset clears the sequence state, the pipeline and the mode register.
// A stalled result holds the result register; the input register then holds too and
// req_stall rises only while both are full.
`default_nettype none

module utf8_stream_validator
   import utf8v_pkg::*;
#(
   parameter int unsigned OFFSET_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic                req_end_of_sequence,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [POS_BITS-1:0]      rsp_position,
   output logic                     rsp_position_found,
   output logic                     rsp_stopped,
   output logic                     rsp_sequence_valid,
   output logic                     rsp_final_result,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   logic       out_free;
   logic       step;
   logic       take;
   logic       report_char_start;
   result_type result;

   utf8v_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .report_char_start (report_char_start)
   );

   utf8v_core #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .data_byte         (in_byte_ff),
      .last              (in_last_ff),
      .report_char_start (report_char_start),
      .result            (result)
   );

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign step      = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_end_of_sequence;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = rsp_ff.position;
   assign rsp_position_found = rsp_ff.position_found;
   assign rsp_stopped        = rsp_ff.stopped;
   assign rsp_sequence_valid = rsp_ff.sequence_valid;
   assign rsp_final_result   = rsp_ff.final_result;

endmodule

`default_nettype wire

// ----- sv/utf8v_checker.sv -----
// Port-level checks for the UTF-8 stream validator, bound to the top level.
`default_nettype none

module utf8v_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_data_byte,
   input wire logic        req_end_of_sequence,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_position,
   input wire logic        rsp_position_found,
   input wire logic        rsp_stopped,
   input wire logic        rsp_sequence_valid,
   input wire logic        rsp_final_result,
   input wire logic        psel,
   input wire logic        penable,
   input wire logic        pwrite,
   input wire logic [2:0]  paddr,
   input wire logic [31:0] pwdata,
   input wire logic [31:0] prdata,
   input wire logic        pready
);

   // No result may survive a reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position) && $stable(rsp_stopped))
      else $error("stalled result changed");

   // A whole-sequence pass only comes with the final byte and never after a stop.
   a_valid_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sequence_valid |-> rsp_final_result && !rsp_stopped)
      else $error("sequence reported valid on a non-final or stopped result");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_position_found |-> rsp_position == 32'd0)
      else $error("position set although no character was found");

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_stopped && !rsp_final_result ##1 rsp_valid
      |-> rsp_stopped)
      else $error("stop flag cleared within a sequence");

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (.*);

`default_nettype wire

// ----- verif/utf8_stream_validator_tb.sv -----
// Self-checking testbench for the UTF-8 stream validator: grammar, report modes and flow control.
`timescale 1ns / 1ps

module utf8_stream_validator_tb
   import utf8v_pkg::*;
();

   localparam int unsigned OFFSET_W = 32;
   localparam logic [2:0] ADDR_MODE = 3'(4 * REG_REPORT_CHAR_START);
   localparam logic [2:0] ADDR_UNMAPPED = ADDR_MODE + 3'd4;
   localparam int QUIET_LIMIT = 4000;
   localparam int SHOW_LIMIT = 10;
   localparam int HOLD_LEN = 48;
   localparam int SETTLE_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_data_byte = '0;
   logic                req_end_of_sequence = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [POS_BITS-1:0] rsp_position;
   logic                rsp_position_found;
   logic                rsp_stopped;
   logic                rsp_sequence_valid;
   logic                rsp_final_result;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [2:0]          paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   always #6 clock = ~clock;

   utf8_stream_validator #(.OFFSET_BITS(OFFSET_W)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_end_of_sequence(req_end_of_sequence),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_position(rsp_position),
      .rsp_position_found(rsp_position_found),
      .rsp_stopped(rsp_stopped),
      .rsp_sequence_valid(rsp_sequence_valid),
      .rsp_final_result(rsp_final_result),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // Mirror of the mode register and of the sequence state inside the validator.
   logic                mode_q = 1'b0;
   logic                halted_q = 1'b0;
   logic [1:0]          need_q = '0;
   rule_type            rule_q = RULE_ANY;
   logic [OFFSET_W-1:0] seen_q = '0;
   logic [OFFSET_W-1:0] pend_q = '0;
   logic [OFFSET_W-1:0] prefix_end_q = '0;
   logic [OFFSET_W-1:0] char_start_q = '0;
   logic                have_char_q = 1'b0;

   result_type reports_due[$];

   int src_idle_pct = 0;
   int sink_stall_pct = 0;
   logic hold_go = 1'b0;
   logic hold_seen = 1'b0;
   int hold_left = 0;

   int errors = 0;
   int bytes_sent = 0;
   int sequences_sent = 0;
   int results_checked = 0;
   int input_stall_cycles = 0;
   int quiet_cycles = 0;

   task automatic flag_error(input string what);
      errors++;
      if (errors <= SHOW_LIMIT)
         $display("MISMATCH: %s", what);
   endtask

   function automatic logic [OFFSET_W-1:0] bump(input logic [OFFSET_W-1:0] v);
      return (v == '1) ? v : v + OFFSET_W'(1);
   endfunction

   function automatic logic cont_fits(input logic [7:0] b, input rule_type r);
      logic tag_ok;
      tag_ok = (b[7:6] == CONT_TAG);
      case (r)
         RULE_A0_BF: return tag_ok && b >= CONT_A0;
         RULE_80_9F: return tag_ok && b <= CONT_9F;
         RULE_90_BF: return tag_ok && b >= CONT_90;
         RULE_80_8F: return tag_ok && b <= CONT_8F;
         default:    return tag_ok;
      endcase
   endfunction

   task automatic close_char();
      char_start_q = pend_q;
      prefix_end_q = bump(seen_q);
      have_char_q = 1'b1;
   endtask

   task automatic clear_sequence();
      halted_q = 1'b0;
      need_q = '0;
      rule_q = RULE_ANY;
      seen_q = '0;
      pend_q = '0;
      prefix_end_q = '0;
      char_start_q = '0;
      have_char_q = 1'b0;
   endtask

   // Advances the mirrored grammar state by one byte and queues the report it produces.
   task automatic validate_byte(input logic [7:0] b, input logic last);
      result_type r;
      if (!halted_q) begin
         if (need_q != 2'd0) begin
            if (!cont_fits(b, rule_q)) begin
               halted_q = 1'b1;
            end else begin
               rule_q = RULE_ANY;
               need_q = need_q - 2'd1;
               if (need_q == 2'd0)
                  close_char();
               seen_q = bump(seen_q);
            end
         end else begin
            pend_q = seen_q;
            if (b <= ASCII_MAX) begin
               close_char();
               seen_q = bump(seen_q);
            end else if (b < LEAD2_MIN || b > LEAD4_MAX) begin
               halted_q = 1'b1;
            end else begin
               if (b <= LEAD2_MAX) begin
                  need_q = 2'd1;
                  rule_q = RULE_ANY;
               end else if (b < LEAD4_MIN) begin
                  need_q = 2'd2;
                  rule_q = (b == LEAD3_MIN) ? RULE_A0_BF :
                           (b == LEAD3_SURR) ? RULE_80_9F : RULE_ANY;
               end else begin
                  need_q = 2'd3;
                  rule_q = (b == LEAD4_MIN) ? RULE_90_BF :
                           (b == LEAD4_MAX) ? RULE_80_8F : RULE_ANY;
               end
               seen_q = bump(seen_q);
            end
         end
      end
      if (mode_q) begin
         r.position = have_char_q ? POS_BITS'(char_start_q) : '0;
         r.position_found = have_char_q;
      end else begin
         r.position = POS_BITS'(prefix_end_q);
         r.position_found = 1'b1;
      end
      r.stopped = halted_q;
      r.sequence_valid = last && !halted_q && need_q == 2'd0;
      r.final_result = last;
      reports_due.push_back(r);
      if (last)
         clear_sequence();
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_sequence <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      validate_byte(b, last);
      bytes_sent++;
      if (last)
         sequences_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (reports_due.size() != 0);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (addr == ADDR_MODE)
         mode_q = data[0];
      @(posedge clock);
   endtask

   task automatic check_mode_readback();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ADDR_MODE;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (prdata !== 32'(mode_q))
         flag_error($sformatf("mode register read: expected %h, got %h",
                              32'(mode_q), prdata));
      @(posedge clock);
   endtask

   function automatic logic [7:0] first_cont(input logic [7:0] lead);
      case (lead)
         LEAD3_MIN:  return 8'($urandom_range(8'hbf, CONT_A0));
         LEAD3_SURR: return 8'($urandom_range(CONT_9F, 8'h80));
         LEAD4_MIN:  return 8'($urandom_range(8'hbf, CONT_90));
         LEAD4_MAX:  return 8'($urandom_range(CONT_8F, 8'h80));
         default:    return {CONT_TAG, 6'($urandom_range(63))};
      endcase
   endfunction

   // Mostly well-formed text; some sequences carry noise, a bad lead, a narrowed
   // continuation out of range, or lose their tail.
   task automatic send_random_sequence();
      logic [7:0] seq[$];
      logic [7:0] lead;
      int n_chars;
      int flaw;
      n_chars = $urandom_range(8, 1);
      for (int c = 0; c < n_chars; c++) begin
         case ($urandom_range(3))
            0: seq.push_back(8'($urandom_range(ASCII_MAX)));
            1: begin
               lead = 8'($urandom_range(LEAD2_MAX, LEAD2_MIN));
               seq.push_back(lead);
               seq.push_back(first_cont(lead));
            end
            2: begin
               if ($urandom_range(1))
                  lead = 8'($urandom_range(LEAD4_MIN - 1, LEAD3_MIN));
               else
                  lead = $urandom_range(1) ? LEAD3_MIN : LEAD3_SURR;
               seq.push_back(lead);
               seq.push_back(first_cont(lead));
               seq.push_back({CONT_TAG, 6'($urandom_range(63))});
            end
            default: begin
               lead = 8'($urandom_range(LEAD4_MAX, LEAD4_MIN));
               seq.push_back(lead);
               seq.push_back(first_cont(lead));
               repeat (2) seq.push_back({CONT_TAG, 6'($urandom_range(63))});
            end
         endcase
      end
      flaw = $urandom_range(9);
      if (flaw == 0) begin
         seq[$urandom_range(seq.size() - 1)] = 8'($urandom());
      end else if (flaw == 1) begin
         repeat ($urandom_range(3, 1))
            if (seq.size() > 1)
               void'(seq.pop_back());
      end else if (flaw == 2) begin
         case ($urandom_range(3))
            0: begin
               seq.push_back(LEAD3_MIN);
               seq.push_back(8'($urandom_range(CONT_9F, 8'h80)));
            end
            1: begin
               seq.push_back(LEAD3_SURR);
               seq.push_back(8'($urandom_range(8'hbf, CONT_A0)));
            end
            2: begin
               seq.push_back(LEAD4_MIN);
               seq.push_back(8'($urandom_range(CONT_8F, 8'h80)));
            end
            default: begin
               seq.push_back(LEAD4_MAX);
               seq.push_back(8'($urandom_range(8'hbf, CONT_90)));
            end
         endcase
         repeat ($urandom_range(3))
            seq.push_back(8'($urandom()));
      end else if (flaw == 3) begin
         case ($urandom_range(2))
            0: lead = 8'($urandom_range(LEAD2_MIN - 1, 8'hc0));
            1: lead = 8'($urandom_range(8'hff, LEAD4_MAX + 1));
            default: lead = {CONT_TAG, 6'($urandom_range(63))};
         endcase
         seq.insert($urandom_range(seq.size()), lead);
      end
      foreach (seq[i])
         send_byte(seq[i], i == seq.size() - 1);
   endtask

   task automatic test_mode_register();
      check_mode_readback();
      csr_write(ADDR_MODE, 32'hffff_ffff);
      check_mode_readback();
      csr_write(ADDR_UNMAPPED, 32'h0000_0000);
      check_mode_readback();
      csr_write(ADDR_MODE, 32'hffff_fffe);
      check_mode_readback();
      csr_write(ADDR_UNMAPPED, 32'hffff_ffff);
      check_mode_readback();
   endtask

   // Start-of-character mode, so that the case with no complete character shows.
   task automatic test_grammar_corners();
      logic [7:0] good[] = '{8'h00, 8'hc2, 8'h80, 8'he0, 8'ha0, 8'hbf, 8'hed, 8'h9f,
                             8'h80, 8'hf0, 8'h90, 8'h80, 8'h80, 8'hf4, 8'h8f, 8'hbf,
                             8'hbf, 8'h7f};
      wait_for_results();
      csr_write(ADDR_MODE, 32'h0000_0001);
      foreach (good[i])
         send_byte(good[i], i == good.size() - 1);
      // A bad lead byte first, then a byte that must be ignored.
      send_byte(8'hff, 1'b0);
      send_byte(8'h41, 1'b1);
      // Continuation below the narrowed range after E0.
      send_byte(8'he0, 1'b0);
      send_byte(8'h9f, 1'b1);
      // Three-byte character cut short by the end of the sequence.
      send_byte(8'he1, 1'b0);
      send_byte(8'h80, 1'b1);
   endtask

   task automatic test_random_streams();
      int idle_plan[4] = '{0, 69, 0, 8};
      int stall_plan[4] = '{0, 0, 69, 8};
      int goal;
      for (int p = 0; p < 4; p++) begin
         wait_for_results();
         csr_write(ADDR_MODE, {31'($urandom()), p[0]});
         src_idle_pct = idle_plan[p];
         sink_stall_pct = stall_plan[p];
         goal = bytes_sent + 225;
         while (bytes_sent < goal)
            send_random_sequence();
      end
   endtask

   // The result side holds off for a long stretch while requests keep coming, then
   // the sender pauses until every report is back before carrying on.
   task automatic test_result_backpressure();
      int goal;
      src_idle_pct = 0;
      sink_stall_pct = 0;
      hold_go = ~hold_go;
      goal = bytes_sent + 30;
      while (bytes_sent < goal)
         send_random_sequence();
      wait_for_results();
      repeat (3) send_random_sequence();
   endtask

   always @(posedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_left <= HOLD_LEN;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < sink_stall_pct);
      end
   end

   always @(posedge clock) begin
      result_type want;
      result_type got;
      string diff;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_position, rsp_position_found, rsp_stopped, rsp_sequence_valid,
                 rsp_final_result};
         results_checked++;
         if (reports_due.size() == 0) begin
            flag_error($sformatf("unexpected report %p", got));
         end else begin
            want = reports_due.pop_front();
            diff = "";
            if (got.position !== want.position)
               diff = {diff, " position"};
            if (got.position_found !== want.position_found)
               diff = {diff, " position_found"};
            if (got.stopped !== want.stopped)
               diff = {diff, " stopped"};
            if (got.sequence_valid !== want.sequence_valid)
               diff = {diff, " sequence_valid"};
            if (got.final_result !== want.final_result)
               diff = {diff, " final_result"};
            if (diff != "")
               flag_error($sformatf("report %0d differs in%s: expected %p, got %p",
                                    results_checked, diff, want, got));
         end
      end
   end

   always @(posedge clock) begin
      if (req_valid && req_stall)
         input_stall_cycles++;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d reports outstanding",
                  QUIET_LIMIT, reports_due.size());
         $display("[utf8_stream_validator] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_mode_register();
      test_grammar_corners();
      test_random_streams();
      test_result_backpressure();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d reports from %0d bytes in %0d sequences, in both report modes.",
               results_checked, bytes_sent, sequences_sent);
      $display("Idle and stall mixes exercised; requests were held back for %0d cycles.",
               input_stall_cycles);
      if (errors == 0)
         $display("[utf8_stream_validator] OK");
      else
         $display("[utf8_stream_validator] ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/utf8v_pkg.sv
sv/utf8v_csr.sv
sv/utf8v_core.sv
sv/utf8_stream_validator.sv
sv/utf8v_checker.sv
verif/utf8_stream_validator_tb.sv
